// ===== rtl/olist_pkg.sv =====
// Shared types and codes for the ordered list engine.
// No dependencies; imported by olist_ctrl, olist_dpath and the top level.
package olist_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int MODE_W       = 2;
  localparam int STATUS_W     = 2;
  localparam int DATA_W       = 32;

  localparam logic [MODE_W-1:0] MODE_FRONT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BACK   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic                op_load;
    logic                k_clr;
    logic                k_inc;
    logic                k_load_next;
    logic                rd_en;
    logic                wr_ins;
    logic                wr_shift;
    logic                cnt_dec;
    logic                out_load;
    logic                out_mem;
    logic                out_last;
    logic [STATUS_W-1:0] out_status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              empty;
    logic              k_end;
    logic              match;
    logic              rd_last;
    logic              out_free;
  } sts_t;

endpackage

// ===== rtl/ordered_list_engine_unit.sv =====
// Ordered list engine top level: bounded ring store of signed 32-bit entries.
// Depends on olist_pkg, olist_ctrl and olist_dpath.
//
//   channel  ports                               direction
//   in       in_valid in_ready in_mode in_value  transaction into the engine
//   out      out_valid out_ready out_status      results; dump gives one per entry,
//            out_data out_last                   out_last on the final one
//
// One transaction at a time. Inserts, and delete or dump of an empty list, go straight to the reply.
// Delete searches from the front for the first match, then shifts every later entry
// one place nearer the front; one entry is searched or shifted per cycle.
// Dump: one store read per cycle paces the walk while out_ready does not stall it.
// Reset clears front and count; the store itself is not cleared.
// A stalled out_ready holds the result register and pauses the walk; the next
// transaction is taken while the last result still waits.
module ordered_list_engine_unit import olist_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [MODE_W-1:0]        in_mode,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STATUS_W-1:0]      out_status,
  output logic signed [DATA_W-1:0] out_data,
  output logic                     out_last
);

  cmd_t cmd;
  sts_t sts;

  olist_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  olist_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_mode    (in_mode),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_data   (out_data),
    .out_last   (out_last)
  );

endmodule

// ===== rtl/olist_ctrl.sv =====
// Sequencer for the ordered list engine: accept, insert, search, shift, dump, reply.
// Depends on olist_pkg; drives olist_dpath through cmd_t and watches sts_t.
module olist_ctrl import olist_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_DUMP   = 3'd4;
  localparam logic [2:0] S_REPLY  = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic                pend_r, pend_nxt;
  logic [STATUS_W-1:0] reply_r, reply_nxt;
  logic                consume;

  assign in_ready = (state_r == S_IDLE);
  assign consume  = pend_r && sts.out_free;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    pend_nxt  = pend_r;
    reply_nxt = reply_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op_load = 1'b1;
          cmd.k_clr   = 1'b1;
          pend_nxt    = 1'b0;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.mode)
          MODE_FRONT, MODE_BACK: begin
            if (sts.full) begin
              reply_nxt = ST_FULL;
            end else begin
              cmd.wr_ins = 1'b1;
              reply_nxt  = ST_OK;
            end
            state_nxt = S_REPLY;
          end
          MODE_DELETE: begin
            if (sts.empty) begin
              reply_nxt = ST_EMPTY;
              state_nxt = S_REPLY;
            end else begin
              state_nxt = S_SEARCH;
            end
          end
          default: begin
            if (sts.empty) begin
              reply_nxt = ST_EMPTY;
              state_nxt = S_REPLY;
            end else begin
              state_nxt = S_DUMP;
            end
          end
        endcase
      end
      S_SEARCH: begin
        if (pend_r && sts.match) begin
          cmd.k_load_next = 1'b1;
          pend_nxt        = 1'b0;
          state_nxt       = S_SHIFT;
        end else if (pend_r && sts.rd_last) begin
          pend_nxt  = 1'b0;
          reply_nxt = ST_NOTFOUND;
          state_nxt = S_REPLY;
        end else begin
          cmd.rd_en = !sts.k_end;
          cmd.k_inc = !sts.k_end;
          pend_nxt  = !sts.k_end;
        end
      end
      S_SHIFT: begin
        // write back the entry read last cycle one place nearer the front
        cmd.wr_shift = pend_r;
        if (!sts.k_end) begin
          cmd.rd_en = 1'b1;
          cmd.k_inc = 1'b1;
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            cmd.cnt_dec = 1'b1;
            reply_nxt   = ST_OK;
            state_nxt   = S_REPLY;
          end
        end
      end
      S_DUMP: begin
        if (consume) begin
          cmd.out_load   = 1'b1;
          cmd.out_mem    = 1'b1;
          cmd.out_last   = sts.rd_last;
          cmd.out_status = ST_OK;
        end
        if (!sts.k_end && (!pend_r || sts.out_free)) begin
          cmd.rd_en = 1'b1;
          cmd.k_inc = 1'b1;
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = pend_r && !sts.out_free;
          if (sts.k_end && (!pend_r || consume)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_REPLY: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_last   = 1'b1;
          cmd.out_status = reply_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
      reply_r <= ST_OK;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      reply_r <= reply_nxt;
    end
  end

endmodule

// ===== rtl/olist_dpath.sv =====
// Datapath for the ordered list engine: ring store, front/count, walk counter, result register.
// Depends on olist_pkg; commanded by olist_ctrl.
module olist_dpath import olist_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic [MODE_W-1:0]        in_mode,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STATUS_W-1:0]      out_status,
  output logic signed [DATA_W-1:0] out_data,
  output logic                     out_last
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;

  logic signed [DATA_W-1:0] mem [CAPACITY];

  logic [MODE_W-1:0]        mode_r;
  logic signed [DATA_W-1:0] value_r;
  logic [IDX_W-1:0]         front_r;
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         k_r;
  logic [CNT_W-1:0]         rd_k_r;
  logic signed [DATA_W-1:0] rd_data_r;

  logic                     out_valid_r;
  logic [STATUS_W-1:0]      out_status_r;
  logic signed [DATA_W-1:0] out_data_r;
  logic                     out_last_r;

  logic [IDX_W-1:0]         front_dec;
  logic [IDX_W-1:0]         rd_addr;
  logic [IDX_W-1:0]         wr_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic                     wr_en;

  function automatic logic [IDX_W-1:0] ring_slot(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign front_dec = (front_r == '0) ? IDX_W'(CAPACITY - 1) : front_r - 1'b1;
  assign rd_addr   = ring_slot(front_r, k_r);
  assign wr_en     = cmd.wr_ins || cmd.wr_shift;
  assign wr_data   = cmd.wr_shift ? rd_data_r : value_r;

  always_comb begin
    if (cmd.wr_shift) begin
      wr_addr = ring_slot(front_r, rd_k_r - 1'b1);
    end else if (mode_r == MODE_FRONT) begin
      wr_addr = front_dec;
    end else begin
      wr_addr = ring_slot(front_r, count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_k_r    <= k_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op_load) begin
      mode_r  <= in_mode;
      value_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (cmd.k_clr) begin
      k_r <= '0;
    end else if (cmd.k_load_next) begin
      k_r <= rd_k_r + 1'b1;
    end else if (cmd.k_inc) begin
      k_r <= k_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (cmd.wr_ins) begin
      if (mode_r == MODE_FRONT) begin
        front_r <= front_dec;
      end
      count_r <= count_r + 1'b1;
    end else if (cmd.cnt_dec) begin
      count_r <= count_r - 1'b1;
    end
  end

  // result register: a finished result waits here while the next transaction starts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_data_r   <= cmd.out_mem ? rd_data_r : '0;
      out_last_r   <= cmd.out_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_last   = out_last_r;

  assign sts.mode     = mode_r;
  assign sts.full     = (count_r == CNT_W'(CAPACITY));
  assign sts.empty    = (count_r == '0);
  assign sts.k_end    = (k_r == count_r);
  assign sts.match    = (rd_data_r == value_r);
  assign sts.rd_last  = (rd_k_r == count_r - 1'b1);
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

// ===== tb/tb_ordered_list_engine_unit.sv =====
// Self-checking testbench for ordered_list_engine_unit: directed and random list transactions,
// with results predicted by a ring store model and checked in order.
// Depends on olist_pkg and the ordered_list_engine_unit RTL.
module tb_ordered_list_engine_unit;
  import olist_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY     = DEF_CAPACITY;
  localparam int RANDOM_OPS   = 355;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] value;
  } list_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] data;
    logic                     last;
  } list_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [MODE_W-1:0]        in_mode = MODE_FRONT;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [STATUS_W-1:0]      out_status;
  logic signed [DATA_W-1:0] out_data;
  logic                     out_last;

  list_op_t     pending_ops[$];
  list_result_t expected_results[$];

  logic signed [DATA_W-1:0] list_ring[CAPACITY];
  int list_front = 0;
  int list_count = 0;

  int error_count  = 0;
  int accepted_ops = 0;
  int burst_left   = 0;
  int gap_left     = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  int pattern_left = 0;
  int ready_pct    = 100;
  int cycle_count  = 0;
  list_op_t next_op;

  ordered_list_engine_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_status(out_status),
    .out_data  (out_data),
    .out_last  (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic queue_op(input logic [MODE_W-1:0] mode, input logic signed [DATA_W-1:0] value);
    list_op_t op;
    op.mode  = mode;
    op.value = value;
    pending_ops.push_back(op);
  endtask

  task automatic push_status(input logic [STATUS_W-1:0] status);
    list_result_t res;
    res.status = status;
    res.data   = '0;
    res.last   = 1'b1;
    expected_results.push_back(res);
  endtask

  task automatic apply_list_op(input logic [MODE_W-1:0] mode,
                               input logic signed [DATA_W-1:0] value);
    int k;
    list_result_t res;
    case (mode)
      MODE_FRONT, MODE_BACK: begin
        if (list_count >= CAPACITY) begin
          push_status(ST_FULL);
        end else begin
          if (mode == MODE_FRONT) begin
            list_front = (list_front + CAPACITY - 1) % CAPACITY;
            list_ring[list_front] = value;
          end else begin
            list_ring[(list_front + list_count) % CAPACITY] = value;
          end
          list_count++;
          push_status(ST_OK);
        end
      end
      MODE_DELETE: begin
        if (list_count == 0) begin
          push_status(ST_EMPTY);
        end else begin
          k = 0;
          while (k < list_count && list_ring[(list_front + k) % CAPACITY] !== value) k++;
          if (k == list_count) begin
            push_status(ST_NOTFOUND);
          end else begin
            while (k + 1 < list_count) begin
              list_ring[(list_front + k) % CAPACITY] = list_ring[(list_front + k + 1) % CAPACITY];
              k++;
            end
            list_count--;
            push_status(ST_OK);
          end
        end
      end
      default: begin
        if (list_count == 0) begin
          push_status(ST_EMPTY);
        end else begin
          for (k = 0; k < list_count; k++) begin
            res.status = ST_OK;
            res.data   = list_ring[(list_front + k) % CAPACITY];
            res.last   = (k + 1 == list_count);
            expected_results.push_back(res);
          end
        end
      end
    endcase
  endtask

  // driver: bursts of transactions with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_list_op(in_mode, in_value);
        accepted_ops++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          next_op = pending_ops.pop_front();
          in_valid <= 1'b1;
          in_mode  <= next_op.mode;
          in_value <= next_op.value;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks results and drives the receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d data=%0d last=%0b",
                   $time, out_status, out_data, out_last);
          error_count++;
        end else begin
          if (out_status !== expected_results[0].status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, expected_results[0].status, out_status);
            error_count++;
          end
          if (out_data !== expected_results[0].data) begin
            $display("%0t: data expected %0d actual %0d",
                     $time, expected_results[0].data, out_data);
            error_count++;
          end
          if (out_last !== expected_results[0].last) begin
            $display("%0t: last expected %0b actual %0b",
                     $time, expected_results[0].last, out_last);
            error_count++;
          end
          void'(expected_results.pop_front());
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && accepted_ops >= 120) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(20, 80);
          case ($urandom_range(0, 3))
            0:       ready_pct = 100;
            1:       ready_pct = 75;
            2:       ready_pct = 40;
            default: ready_pct = 15;
          endcase
        end else begin
          pattern_left--;
        end
        out_ready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  initial begin
    int i;
    int r;
    int bias;
    logic [MODE_W-1:0] mode;
    logic signed [DATA_W-1:0] value;

    // directed: empty list, extremes, wrap, full store, duplicates
    queue_op(MODE_DUMP, 32'sd0);
    queue_op(MODE_DELETE, 32'sd5);
    queue_op(MODE_BACK, 32'sh7FFF_FFFF);
    queue_op(MODE_FRONT, 32'sh8000_0000);
    queue_op(MODE_BACK, 32'sd0);
    queue_op(MODE_FRONT, -32'sd1);
    for (i = 0; i < CAPACITY - 4; i++)
      queue_op((i % 2 == 0) ? MODE_FRONT : MODE_BACK, (i % 3 == 0) ? 32'sd7 : i);
    queue_op(MODE_FRONT, 32'sd1);
    queue_op(MODE_BACK, 32'sd2);
    queue_op(MODE_DUMP, 32'sh5A5A_5A5A);
    queue_op(MODE_DELETE, 32'sd12345);
    queue_op(MODE_DELETE, 32'sd7);
    queue_op(MODE_DELETE, 32'sh8000_0000);
    queue_op(MODE_DELETE, 32'sh7FFF_FFFF);
    queue_op(MODE_DUMP, 32'sd0);

    // random: alternating fill-heavy, delete-heavy and balanced stretches
    for (i = 0; i < RANDOM_OPS; i++) begin
      bias = (i / 45) % 3;
      r = $urandom_range(0, 99);
      if (r < 12) begin
        mode = MODE_DUMP;
      end else if (bias == 0) begin
        mode = (r < 82) ? (r[0] ? MODE_FRONT : MODE_BACK) : MODE_DELETE;
      end else if (bias == 1) begin
        mode = (r < 72) ? MODE_DELETE : (r[0] ? MODE_FRONT : MODE_BACK);
      end else begin
        mode = (r < 56) ? MODE_DELETE : (r[0] ? MODE_FRONT : MODE_BACK);
      end
      r = $urandom_range(0, 9);
      if (r < 6)
        value = $signed($urandom_range(0, 7)) - 4;
      else if (r == 6)
        value = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      else
        value = $urandom;
      queue_op(mode, value);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_ops.size() > 0 || in_valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycle_count);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== ordered_list_engine_unit.f =====
rtl/olist_pkg.sv
rtl/olist_ctrl.sv
rtl/olist_dpath.sv
rtl/ordered_list_engine_unit.sv
tb/tb_ordered_list_engine_unit.sv
